// File: rtl/sai_pkg.sv
// ----------------------------------------------------------------------------
// Sorted array package
// Shared widths, operation and status codes, and the control bundle that
// the top level hands to every cell of the row.
// ----------------------------------------------------------------------------
package sai_pkg;

  // Field widths of the beats.
  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 2;
  localparam int IDX_W   = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Default number of cells in the row.
  localparam int CAPACITY_DEF = 16;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

  // Control broadcast to the cells.
  typedef struct packed {
    logic cmp_en;   // capture compare flags against the incoming value
    logic ins_en;   // shift up and place the value
    logic rem_en;   // shift down over the matching entry
  } cell_ctrl_t;

endpackage

// File: rtl/sorted_array_insert_remove_top.sv
// ----------------------------------------------------------------------------
// Sorted array with insert and remove
// Keeps signed entries in ascending order in a row of cells and answers
// insert, remove and read operations with one result beat each.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_func, in_value, in_index)
//   carries one operation per beat. The output channel (out_valid,
//   out_stall, out_status, out_read_value, out_count) returns exactly one
//   result beat per operation, in order.
//   In an operation, every cell first latches its compare flags against
//   in_value at the accepting edge; then, once the output register is free,
//   the cells shift in parallel and the result is loaded into the output
//   register. A new beat is taken only after that update, so the block never
//   works on more than one operation at a time.
//   The output register decouples the sides: a new operation is accepted
//   while an earlier result still waits. If the receiver stalls and the
//   output register is full, the pending operation holds before its update
//   and in_stall stays high until the register frees.
//   Reset empties the store (count zero); entry contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_array_insert_remove_top #(
  parameter int CAPACITY = sai_pkg::CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [sai_pkg::FUNC_W-1:0]            in_func,
  input  logic signed [sai_pkg::DATA_W-1:0]     in_value,
  input  logic [sai_pkg::IDX_W-1:0]             in_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [sai_pkg::STAT_W-1:0]            out_status,
  output logic signed [sai_pkg::DATA_W-1:0]     out_read_value,
  output logic [sai_pkg::COUNT_W-1:0]           out_count
);
  import sai_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RD_N  = (CAPACITY < (1 << IDX_W)) ? CAPACITY : (1 << IDX_W);

  logic                     busy_r;
  logic                     busy_nxt;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [FUNC_W-1:0]        op_func_r;
  logic signed [DATA_W-1:0] op_value_r;
  logic [IDX_W-1:0]         op_index_r;

  logic                     out_valid_r;
  logic [STAT_W-1:0]        out_status_r;
  logic [STAT_W-1:0]        status_nxt;
  logic signed [DATA_W-1:0] out_read_value_r;
  logic signed [DATA_W-1:0] rd_nxt;
  logic [COUNT_W-1:0]       out_count_r;

  logic                     accept;
  logic                     commit;
  logic                     full;
  logic                     found;
  logic                     idx_ok;
  logic signed [DATA_W-1:0] rd_data;
  cell_ctrl_t               ctrl;

  logic signed [DATA_W-1:0] ent   [CAPACITY];
  logic [CAPACITY-1:0]      lt;
  logic [CAPACITY-1:0]      hit;

  // Handshake: one operation in flight at a time.
  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign commit   = busy_r && (!out_valid_r || !out_stall);

  // Operation decode against the current count.
  assign full   = cnt_r == CNT_W'(CAPACITY);
  assign found  = |hit;
  assign idx_ok = (32'(op_index_r) < 32'(cnt_r)) && (32'(op_index_r) < CAPACITY);

  assign ctrl.cmp_en = accept;
  assign ctrl.ins_en = commit && (op_func_r == FUNC_INSERT) && !full;
  assign ctrl.rem_en = commit && (op_func_r == FUNC_REMOVE) && found;

  // Row of cells; each sees its neighbors' entries and left compare flag.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_e;
    logic signed [DATA_W-1:0] right_e;
    logic                     left_l;
    if (g == 0) begin : g_first
      assign left_e = op_value_r;
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_e = ent[g-1];
      assign left_l = lt[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_e = ent[g];
    end else begin : g_inner
      assign right_e = ent[g+1];
    end
    sai_cell #(
      .POS   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk           (clk),
      .ctrl_i        (ctrl),
      .count_i       (cnt_r),
      .cmp_value_i   (in_value),
      .wr_value_i    (op_value_r),
      .left_entry_i  (left_e),
      .right_entry_i (right_e),
      .left_lt_i     (left_l),
      .entry_o       (ent[g]),
      .lt_o          (lt[g]),
      .hit_o         (hit[g])
    );
  end

  // Read port over the cells that the index field can address.
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (32'(op_index_r) == k) begin
        rd_data = ent[k];
      end
    end
  end

  // Result and next count.
  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    rd_nxt     = '0;
    case (op_func_r)
      FUNC_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (found) begin
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      FUNC_READ: begin
        if (idx_ok) begin
          rd_nxt = rd_data;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Busy flag follows accept and commit.
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (commit) begin
      busy_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (commit) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operation and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func_r  <= in_func;
      op_value_r <= in_value;
      op_index_r <= in_index;
    end
    if (commit) begin
      out_status_r     <= status_nxt;
      out_read_value_r <= rd_nxt;
      out_count_r      <= COUNT_W'(cnt_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;

`ifndef SYNTHESIS
  // The count never passes the number of cells.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= CAPACITY)
    else $error("count exceeds capacity");

  // An insert update grows the count by exactly one.
  a_ins_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins_en |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("insert did not grow count by one");

  // A remove update shrinks the count by exactly one.
  a_rem_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rem_en |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("remove did not shrink count by one");

  // At most one cell marks the first match of a remove.
  a_hit_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot0(hit))
    else $error("several cells claim the match");

  // Insert and remove updates never fire together.
  a_upd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.ins_en && ctrl.rem_en))
    else $error("insert and remove update at once");
`endif

endmodule

// File: rtl/sai_cell.sv
// ----------------------------------------------------------------------------
// Sorted array cell
// Holds one entry. Compares it against the broadcast value, and on an
// update takes the value, the left neighbor's entry or the right neighbor's.
// ----------------------------------------------------------------------------
module sai_cell #(
  parameter int unsigned POS   = 0,
  parameter int          CNT_W = 5
) (
  input  logic                                  clk,
  input  sai_pkg::cell_ctrl_t                   ctrl_i,
  input  logic [CNT_W-1:0]                      count_i,
  input  logic signed [sai_pkg::DATA_W-1:0]     cmp_value_i,
  input  logic signed [sai_pkg::DATA_W-1:0]     wr_value_i,
  input  logic signed [sai_pkg::DATA_W-1:0]     left_entry_i,
  input  logic signed [sai_pkg::DATA_W-1:0]     right_entry_i,
  input  logic                                  left_lt_i,
  output logic signed [sai_pkg::DATA_W-1:0]     entry_o,
  output logic                                  lt_o,
  output logic                                  hit_o
);
  import sai_pkg::*;

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;
  logic                     vld;
  logic                     vld_r;
  logic                     lt_r;
  logic                     eq_r;

  // The cell holds a live entry when its position is below the count.
  assign vld = 32'(count_i) > POS;

  // Compare flags, captured when an operation is accepted.
  always_ff @(posedge clk) begin
    if (ctrl_i.cmp_en) begin
      vld_r <= vld;
      lt_r  <= vld && (entry_r < cmp_value_i);
      eq_r  <= entry_r == cmp_value_i;
    end
  end

  // Cells at or past the insert point shift up; at or past the match, down.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl_i.ins_en && !lt_r) begin
      entry_nxt = left_lt_i ? wr_value_i : left_entry_i;
    end else if (ctrl_i.rem_en && !lt_r) begin
      entry_nxt = right_entry_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign lt_o    = lt_r;
  // First live entry not below the value, and equal to it.
  assign hit_o   = vld_r && eq_r && !lt_r && left_lt_i;

endmodule

// File: tb/sv/sorted_array_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted array result checker
// Watches both channels of the sorted array, keeps its own ordered store to
// predict one result per accepted operation, and compares every result beat
// field by field against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module sorted_array_checker #(
  parameter int CAPACITY = sai_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [sai_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [sai_pkg::DATA_W-1:0] in_value,
  input  logic [sai_pkg::IDX_W-1:0]         in_index,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [sai_pkg::STAT_W-1:0]        out_status,
  input  logic signed [sai_pkg::DATA_W-1:0] out_read_value,
  input  logic [sai_pkg::COUNT_W-1:0]       out_count,
  output int                                fail_count,
  output int                                pending,
  output int                                results_checked,
  output int                                full_seen,
  output int                                miss_seen,
  output int                                range_seen
);
  import sai_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
  } op_result_t;

  // Shadow copy of the store: ascending signed entries below shadow_count.
  logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
  int unsigned              shadow_count;
  op_result_t               awaited_results [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    full_seen       = 0;
    miss_seen       = 0;
    range_seen      = 0;
    shadow_count    = 0;
  end

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
  endtask

  // Apply one operation to the shadow store and return the result it causes.
  function automatic op_result_t sorted_store_update(
    input logic [FUNC_W-1:0]        func,
    input logic signed [DATA_W-1:0] value,
    input logic [IDX_W-1:0]         index
  );
    op_result_t  res;
    int unsigned pos;
    int unsigned i;
    res        = '0;
    res.status = ST_OK;
    pos        = 0;
    case (func)
      FUNC_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // Place the value ahead of the first entry that is not smaller.
          while (pos < shadow_count && shadow_entries[pos] < value) pos++;
          for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos] = value;
          shadow_count++;
        end
      end
      FUNC_REMOVE: begin
        // Drop the first equal entry and close the gap.
        while (pos < shadow_count && shadow_entries[pos] != value) pos++;
        if (pos >= shadow_count) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      FUNC_READ: begin
        if (index < shadow_count) begin
          res.read_value = shadow_entries[index];
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: begin
        // The spare operation code leaves everything as it is.
      end
    endcase
    res.count = COUNT_W'(shadow_count);
    return res;
  endfunction

  // Results are matched before new operations are predicted, since a result
  // never belongs to the operation accepted at the same edge.
  always @(posedge clk) begin
    op_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding (status %0d)",
                                    out_status));
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d, expected %0d",
                                      out_status, want.status));
          if (out_read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %0d, expected %0d",
                                      out_read_value, want.read_value));
          if (out_count !== want.count)
            report_mismatch($sformatf("count got %0d, expected %0d",
                                      out_count, want.count));
        end
      end
      if (in_valid && !in_stall) begin
        want = sorted_store_update(in_func, in_value, in_index);
        case (want.status)
          ST_FULL:      full_seen++;
          ST_NOT_FOUND: miss_seen++;
          ST_RANGE:     range_seen++;
          default:      ;
        endcase
        // Queue the prediction behind the ones still outstanding.
        awaited_results = {awaited_results, want};
      end
    end
    pending = awaited_results.size();
  end

endmodule

// File: tb/sv/sorted_array_insert_remove_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted array testbench
// Drives insert, remove and read operations into the sorted array through a
// short directed opening and then random fill and drain sequences under
// several idling patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_array_insert_remove_top_tb;
  import sai_pkg::*;

  localparam int CAPACITY       = CAPACITY_DEF;
  localparam int RANDOM_OPS     = 1932;
  localparam int PHASE_COUNT    = 4;
  localparam int SWING_LEN      = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int POOL_SIZE      = 16;

  // The fourth operation code is unused by the block.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh80000000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [FUNC_W-1:0]        in_func;
  logic signed [DATA_W-1:0] in_value;
  logic [IDX_W-1:0]         in_index;
  logic                     out_valid;
  logic                     out_stall;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_read_value;
  logic [COUNT_W-1:0]       out_count;

  int fail_count;
  int pending;
  int results_checked;
  int full_seen;
  int miss_seen;
  int range_seen;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int ops_sent       = 0;
  int quiet_cycles   = 0;

  // Recently inserted values, reused so that removes find their targets.
  logic signed [DATA_W-1:0] value_pool [POOL_SIZE];

  sorted_array_insert_remove_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_value      (in_value),
    .in_index      (in_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_read_value(out_read_value),
    .out_count     (out_count)
  );

  sorted_array_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_value       (in_value),
    .in_index       (in_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .full_seen      (full_seen),
    .miss_seen      (miss_seen),
    .range_seen     (range_seen)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls at random, at the rate set for the current phase.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d cycles without a beat", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offer one operation beat, with random idle cycles ahead of it.
  task automatic send_op(
    input logic [FUNC_W-1:0]        func,
    input logic signed [DATA_W-1:0] value,
    input logic [IDX_W-1:0]         index
  );
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_func  = func;
    in_value = value;
    in_index = index;
    do @(posedge clk); while (in_stall);
    ops_sent++;
  endtask

  // Values lean toward earlier inserts, small numbers and the extremes.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return value_pool[$urandom_range(0, POOL_SIZE-1)];
    if (sel < 60) return $signed($urandom_range(0, 8)) - 4;
    if (sel < 70) return ($urandom_range(0, 1) != 0) ? DATA_MAX : DATA_MIN;
    return $urandom;
  endfunction

  // One random operation; the insert and remove shares steer fill or drain.
  task automatic random_op(input int insert_pct, input int remove_pct);
    int unsigned              sel;
    logic signed [DATA_W-1:0] v;
    sel = $urandom_range(0, 99);
    v   = pick_value();
    if (sel < insert_pct) begin
      value_pool[$urandom_range(0, POOL_SIZE-1)] = v;
      send_op(FUNC_INSERT, v, IDX_W'($urandom));
    end else if (sel < insert_pct + remove_pct) begin
      send_op(FUNC_REMOVE, v, IDX_W'($urandom));
    end else if (sel < 97) begin
      send_op(FUNC_READ, $urandom, IDX_W'($urandom_range(0, 15)));
    end else begin
      send_op(FUNC_UNUSED, v, IDX_W'($urandom));
    end
  endtask

  // Main stimulus sequence.
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_func  = FUNC_INSERT;
    in_value = '0;
    in_index = '0;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed opening: empty store, extremes, duplicates and misses.
    send_op(FUNC_READ,   '0,       IDX_W'(0));
    send_op(FUNC_READ,   DATA_MAX, IDX_W'(15));
    send_op(FUNC_REMOVE, 32'sd5,   IDX_W'(0));
    send_op(FUNC_UNUSED, DATA_MIN, IDX_W'(15));
    send_op(FUNC_INSERT, 32'sd0,   IDX_W'(0));
    send_op(FUNC_INSERT, 32'sd0,   IDX_W'(15));
    send_op(FUNC_INSERT, DATA_MAX, IDX_W'(0));
    send_op(FUNC_INSERT, DATA_MIN, IDX_W'(0));
    send_op(FUNC_INSERT, -32'sd1,  IDX_W'(0));
    send_op(FUNC_INSERT, 32'sd1,   IDX_W'(0));
    send_op(FUNC_READ,   '0,       IDX_W'(0));
    send_op(FUNC_READ,   '0,       IDX_W'(5));
    send_op(FUNC_READ,   '0,       IDX_W'(6));
    send_op(FUNC_REMOVE, 32'sd0,   IDX_W'(0));
    send_op(FUNC_REMOVE, 32'sd0,   IDX_W'(0));
    send_op(FUNC_REMOVE, 32'sd0,   IDX_W'(0));
    send_op(FUNC_REMOVE, DATA_MIN, IDX_W'(0));
    send_op(FUNC_REMOVE, DATA_MAX, IDX_W'(0));
    send_op(FUNC_READ,   '0,       IDX_W'(0));
    send_op(FUNC_READ,   '0,       IDX_W'(1));

    // Random part: alternate fill and drain swings in each idling phase.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
      endcase
      for (int n = 0; n < RANDOM_OPS / PHASE_COUNT; n++) begin
        if (((n / SWING_LEN) % 2) == 0) begin
          random_op(70, 15);
        end else begin
          random_op(15, 70);
        end
      end
    end

    // Let the outstanding results drain.
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d operations under four idling patterns; %0d results compared.",
             ops_sent, results_checked);
    $display("Inserts into a full store: %0d, removes of absent values: %0d, %s %0d.",
             full_seen, miss_seen, "reads out of range:", range_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
